### src/clt_pkg.sv
// Shared types, codes and helper functions of the configuration line tokenizer.
// No dependencies; every other file of the block imports this package.
package clt_pkg;

  // Width of the length limit register and its value after reset.
  localparam int unsigned CFG_W           = 12;
  localparam logic [CFG_W-1:0] MAX_LEN_RST = 12'd255;

  // Defaults for the top level parameters.
  localparam int unsigned LEN_BITS_DEF    = 12;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Scan modes of the front end.
  localparam logic [2:0] M_IDLE        = 3'd0;
  localparam logic [2:0] M_BARE        = 3'd1;
  localparam logic [2:0] M_QUOTED      = 3'd2;
  localparam logic [2:0] M_SKIP_BARE   = 3'd3;
  localparam logic [2:0] M_SKIP_QUOTED = 3'd4;
  localparam logic [2:0] M_COMMENT     = 3'd5;

  // End status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LONG   = 2'd1;
  localparam logic [1:0] ST_UNTERM = 2'd2;

  // Characters with a special meaning.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_R = 8'h72;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic [1:0] end_status;
    logic       run_last;
  } clt_res_t;

  // Up to two results collected while one input item is handled.
  typedef struct packed {
    logic [1:0] n;
    clt_res_t   r0;
    clt_res_t   r1;
  } clt_acc_t;

  // Queue entry: the results of one input item.
  typedef struct packed {
    logic     two;
    clt_res_t r0;
    clt_res_t r1;
  } clt_pkt_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
           (b == CH_CR);
  endfunction

  function automatic logic [7:0] esc_map(logic [7:0] b);
    logic [7:0] t;
    t = b;
    if (b == CH_LOW_R) t = CH_CR;
    else if (b == CH_LOW_N) t = CH_LF;
    else if (b == CH_ZERO) t = CH_NUL;
    return t;
  endfunction

  function automatic clt_res_t mk_res(logic [7:0] b, logic v, logic e, logic [1:0] s);
    clt_res_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.token_end  = e;
    r.end_status = s;
    r.run_last   = 1'b0;
    return r;
  endfunction

  // Append a result; a third one is dropped (it cannot occur).
  function automatic clt_acc_t put_res(clt_acc_t a, clt_res_t r);
    clt_acc_t o;
    o = a;
    if (a.n == 2'd0) begin
      o.r0 = r;
      o.n  = 2'd1;
    end else if (a.n == 2'd1) begin
      o.r1 = r;
      o.n  = 2'd2;
    end
    return o;
  endfunction

endpackage

### src/clt_front.sv
// Front end of the tokenizer: takes one byte per cycle while the queue has room, keeps
// the scan state and limit register, hands up to two results to the queue. Uses clt_pkg.
module clt_front import clt_pkg::*; #(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             q_full_i,
  output logic             push_o,
  output clt_pkt_t         pkt_o
);

  localparam int unsigned CW = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;
  localparam logic [CW-1:0] CAP = CW'((64'd1 << LEN_BITS) - 64'd1);

  typedef struct packed {
    logic [2:0]          mode;
    logic [LEN_BITS-1:0] cnt;
    logic                slash;
    logic                esc;
    clt_acc_t            acc;
  } ctx_t;

  logic [CFG_W-1:0]    max_len_q;
  logic [2:0]          mode_q;
  logic [LEN_BITS-1:0] cnt_q;
  logic                slash_q;
  logic                esc_q;
  logic [LEN_BITS-1:0] lim;
  logic                accept;
  ctx_t                cur;
  ctx_t                nxt;

  function automatic ctx_t go_idle(ctx_t x);
    ctx_t o;
    o       = x;
    o.mode  = M_IDLE;
    o.cnt   = '0;
    o.slash = 1'b0;
    o.esc   = 1'b0;
    return o;
  endfunction

  function automatic ctx_t end_tok(ctx_t x, logic [1:0] s);
    ctx_t o;
    o     = x;
    o.acc = put_res(o.acc, mk_res(CH_NUL, 1'b0, 1'b1, s));
    return go_idle(o);
  endfunction

  function automatic ctx_t content(ctx_t x, logic [7:0] b, logic [LEN_BITS-1:0] l);
    ctx_t o;
    o = x;
    if (x.cnt >= l) begin
      o.acc   = put_res(o.acc, mk_res(CH_NUL, 1'b0, 1'b1, ST_LONG));
      o.mode  = (x.mode == M_QUOTED) ? M_SKIP_QUOTED : M_SKIP_BARE;
      o.cnt   = '0;
      o.slash = 1'b0;
      o.esc   = (b == CH_BSL);
    end else if (b == CH_BSL) begin
      o.esc = 1'b1;
    end else begin
      o.acc = put_res(o.acc, mk_res(b, 1'b1, 1'b0, ST_OK));
      o.cnt = x.cnt + 1'b1;
    end
    return o;
  endfunction

  function automatic ctx_t escaped(ctx_t x, logic [7:0] b);
    ctx_t o;
    o     = x;
    o.esc = 1'b0;
    o.acc = put_res(o.acc, mk_res(esc_map(b), 1'b1, 1'b0, ST_OK));
    o.cnt = x.cnt + 1'b1;
    return o;
  endfunction

  function automatic ctx_t bare(ctx_t x, logic [7:0] b, logic [LEN_BITS-1:0] l);
    ctx_t o;
    o = x;
    if ((b == CH_NUL) || (!x.esc && is_ws(b))) o = end_tok(x, ST_OK);
    else if (x.esc) o = escaped(x, b);
    else if (b == CH_SLASH) o.slash = 1'b1;
    else o = content(x, b, l);
    return o;
  endfunction

  function automatic ctx_t skip_bare(ctx_t x, logic [7:0] b);
    ctx_t o;
    logic done;
    o    = x;
    done = 1'b0;
    if (b == CH_NUL) begin
      o = go_idle(x);
    end else if (x.esc) begin
      o.esc = 1'b0;
    end else begin
      if (x.slash) begin
        o.slash = 1'b0;
        if (b == CH_SLASH) begin
          o      = go_idle(o);
          o.mode = M_COMMENT;
          done   = 1'b1;
        end
      end
      if (!done) begin
        if (is_ws(b)) o = go_idle(o);
        else if (b == CH_BSL) o.esc = 1'b1;
        else if (b == CH_SLASH) o.slash = 1'b1;
      end
    end
    return o;
  endfunction

  // A held slash turned out to be content: emit it, then handle the new byte.
  function automatic ctx_t flush(ctx_t x, logic [7:0] b, logic [LEN_BITS-1:0] l);
    ctx_t o;
    o       = x;
    o.slash = 1'b0;
    o       = content(o, CH_SLASH, l);
    if (o.mode == M_BARE) o = bare(o, b, l);
    else o = skip_bare(o, b);
    return o;
  endfunction

  function automatic ctx_t step(ctx_t x, logic [7:0] b, logic [LEN_BITS-1:0] l);
    ctx_t o;
    o     = x;
    o.acc = '0;
    unique case (x.mode)
      M_IDLE: begin
        if (x.slash) begin
          o.slash = 1'b0;
          if (b == CH_SLASH) begin
            o.mode = M_COMMENT;
          end else begin
            o.mode = M_BARE;
            o.cnt  = '0;
            o      = flush(o, b, l);
          end
        end else if ((b == CH_NUL) || is_ws(b)) begin
          o = go_idle(o);
        end else if (b == CH_SLASH) begin
          o.slash = 1'b1;
        end else if (b == CH_DQUOTE) begin
          o.mode = M_QUOTED;
          o.cnt  = '0;
        end else begin
          o.mode = M_BARE;
          o.cnt  = '0;
          o      = content(o, b, l);
        end
      end
      M_BARE: begin
        if (x.slash) begin
          if (b == CH_SLASH) begin
            o      = end_tok(o, ST_OK);
            o.mode = M_COMMENT;
          end else begin
            o = flush(o, b, l);
          end
        end else begin
          o = bare(o, b, l);
        end
      end
      M_QUOTED: begin
        if (b == CH_NUL) o = end_tok(o, ST_UNTERM);
        else if (x.esc) o = escaped(o, b);
        else if (b == CH_DQUOTE) o = end_tok(o, ST_OK);
        else o = content(o, b, l);
      end
      M_SKIP_BARE: o = skip_bare(o, b);
      M_SKIP_QUOTED: begin
        if (b == CH_NUL) o = go_idle(o);
        else if (x.esc) o.esc = 1'b0;
        else if (b == CH_DQUOTE) o = go_idle(o);
        else if (b == CH_BSL) o.esc = 1'b1;
      end
      M_COMMENT: begin
        if (b == CH_NUL) o = go_idle(o);
      end
      default: o = go_idle(o);
    endcase
    if (o.acc.n == 2'd2) o.acc.r1.run_last = 1'b1;
    else if (o.acc.n == 2'd1) o.acc.r0.run_last = 1'b1;
    return o;
  endfunction

  // Effective limit: the register value, capped at the counter range.
  always_comb begin
    if (CW'(max_len_q) < CAP) lim = LEN_BITS'(CW'(max_len_q));
    else lim = LEN_BITS'(CAP);
  end

  assign accept = in_valid_i && !q_full_i;

  always_comb begin
    cur.mode  = mode_q;
    cur.cnt   = cnt_q;
    cur.slash = slash_q;
    cur.esc   = esc_q;
    cur.acc   = '0;
    nxt       = step(cur, in_byte_i, lim);
  end

  assign push_o    = accept && (nxt.acc.n != 2'd0);
  assign pkt_o.two = (nxt.acc.n == 2'd2);
  assign pkt_o.r0  = nxt.acc.r0;
  assign pkt_o.r1  = nxt.acc.r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      cnt_q   <= '0;
      slash_q <= 1'b0;
      esc_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= nxt.mode;
      cnt_q   <= nxt.cnt;
      slash_q <= nxt.slash;
      esc_q   <= nxt.esc;
    end
  end

endmodule

### src/clt_queue.sv
// Short queue of result packets between the front and back ends of the tokenizer.
// Uses clt_pkg for the packet type.
module clt_queue import clt_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  clt_pkt_t pkt_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     nonempty_o,
  output clt_pkt_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  clt_pkt_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_q;
  logic [PW-1:0]   rd_q;
  logic [NW-1:0]   cnt_q;
  logic            do_pop;

  assign full_o     = (cnt_q == NW'(DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= pkt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### src/clt_back.sv
// Back end of the tokenizer: splits queued packets into single result items and
// holds each in the output register until the receiver takes it. Uses clt_pkg.
module clt_back import clt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_nonempty_i,
  input  clt_pkt_t q_head_i,
  output logic     q_pop_o,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output clt_res_t out_res_o
);

  logic     valid_q, valid_d;
  logic     phase_q, phase_d;
  clt_res_t res_q, res_d;
  logic     load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    res_d   = res_q;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = q_nonempty_i;
      if (q_nonempty_i) begin
        res_d = phase_q ? q_head_i.r1 : q_head_i.r0;
        if (!phase_q && q_head_i.two) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          q_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

### src/config_line_tokenizer.sv
// Top level of the configuration line tokenizer: front end, packet queue and back end.
// Depends on clt_pkg, clt_front, clt_queue and clt_back.
//
// Usage: text enters one byte per item on the in channel (in_valid_i, in_stall_o,
// in_byte_i). A zero byte ends the string. Token bytes leave on the out channel as
// items with byte_valid_o set; each token is closed by an item with token_end_o set
// and a status in end_status_o (ok, too long, unterminated quote). run_last_o marks
// the last item caused by one input byte; one byte causes zero, one or two items.
// The length limit is written through cfg_we_i / cfg_wdata_i while the block is idle.
//
// Throughput: one input byte per cycle while in_stall_o is low, and one output item
// per cycle while out_stall_i is low. The front end handles a byte in the cycle it
// is accepted; the back end sends the two items of a byte one after the other, so
// the queue absorbs those bursts. When the queue is empty, an accepted byte reaches
// its first item through one queue entry and then the output register.
// When the receiver stalls, the output register holds its item and the queue fills;
// in_stall_o rises once the queue is full. Reset returns the scanner to idle between
// tokens, clears the queue and sets the limit to 255. No clearing pass is needed.
module config_line_tokenizer import clt_pkg::*; #(
  parameter int unsigned LEN_BITS    = LEN_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             token_end_o,
  output logic [1:0]       end_status_o,
  output logic             run_last_o
);

  logic     push;
  clt_pkt_t push_pkt;
  logic     q_full;
  logic     q_pop;
  logic     q_nonempty;
  clt_pkt_t q_head;
  clt_res_t out_res;

  // The front end only stalls when the queue has no free entry.
  assign in_stall_o = q_full;

  clt_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .pkt_o       (push_pkt)
  );

  clt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pkt_i      (push_pkt),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .head_o     (q_head)
  );

  clt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (q_nonempty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_res_o    (out_res)
  );

  assign out_byte_o   = out_res.out_byte;
  assign byte_valid_o = out_res.byte_valid;
  assign token_end_o  = out_res.token_end;
  assign end_status_o = out_res.end_status;
  assign run_last_o   = out_res.run_last;

endmodule

### src/clt_checker.sv
// Port-level checks of the configuration line tokenizer and the bind that attaches them.
// Depends on clt_pkg and config_line_tokenizer.
module clt_port_checks import clt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [7:0]       out_byte_o,
  input logic             byte_valid_o,
  input logic             token_end_o,
  input logic [1:0]       end_status_o,
  input logic             run_last_o
);

  // A stalled item stays on the port unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(token_end_o) && $stable(end_status_o) && $stable(run_last_o))
    else $error("stalled output item changed");

  // Every item is either a token byte or a token end, never both.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o != token_end_o))
    else $error("output item is neither or both of byte and end");

  // Byte items carry an ok status; end items carry a zero byte and a defined status.
  a_byte_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> (end_status_o == ST_OK))
    else $error("byte item with nonzero status");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_end_o |-> (out_byte_o == CH_NUL) &&
    ((end_status_o == ST_OK) || (end_status_o == ST_LONG) || (end_status_o == ST_UNTERM)))
    else $error("end item with bad byte or status");

endmodule

bind config_line_tokenizer clt_port_checks u_clt_port_checks (.*);
